### rtl/tlvpv_pkg.sv
// shared constants and types for the tlv packet validator
package tlvpv_pkg;

   // header and attribute header sizes in bytes
   localparam int HEADER_BYTES      = 8;
   localparam int ATTR_HEADER_BYTES = 4;

   // byte offset and chain boundary width, and saturation point of the offset
   localparam int OFFSET_W = 17;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
   localparam logic [OFFSET_W-1:0] HDR_LEN    = OFFSET_W'(HEADER_BYTES);

   localparam int COUNT_W = 15;

   // one input byte of the request buffer
   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } item_type;

   // one validation result
   typedef struct packed {
      logic               packet_valid;
      logic [31:0]        request_number;
      logic [15:0]        request_type;
      logic [15:0]        packet_length;
      logic [COUNT_W-1:0] attribute_count;
   } result_type;

endpackage

### rtl/tlvpv_if.sv
// valid/ready channel interfaces for request bytes and validation results

interface tlvpv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface tlvpv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          packet_valid;
   logic [31:0]                   request_number;
   logic [15:0]                   request_type;
   logic [15:0]                   packet_length;
   logic [tlvpv_pkg::COUNT_W-1:0] attribute_count;

   modport source (output valid, output packet_valid, output request_number,
                   output request_type, output packet_length,
                   output attribute_count, input ready);
   modport sink   (input valid, input packet_valid, input request_number,
                   input request_type, input packet_length,
                   input attribute_count, output ready);
endinterface

### rtl/tlvpv_walker.sv
// header capture and attribute length chain walk, one byte per step
module tlvpv_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tlvpv_pkg::item_type   item,
   output tlvpv_pkg::result_type result
);

   logic [tlvpv_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [63:0]                    shift_ff, shift_in;
   logic [tlvpv_pkg::OFFSET_W-1:0] bound_ff, bound_in;
   logic [7:0]                     cap_ff, cap_in;
   logic                           err_ff, err_in;
   logic [tlvpv_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                           in_header;
   logic                           walking;
   logic                           len_hi;
   logic                           len_lo;
   logic [15:0]                    attr_len;
   logic [tlvpv_pkg::OFFSET_W-1:0] plen_ext;
   logic [tlvpv_pkg::OFFSET_W-1:0] bound_sum;
   logic [tlvpv_pkg::OFFSET_W-1:0] new_plen;
   logic                           short_buf;

   // decode where this byte falls in the packet
   assign in_header = offset_ff < tlvpv_pkg::HDR_LEN;
   assign plen_ext  = {1'b0, shift_ff[15:0]};
   assign walking   = !in_header && !err_ff && (bound_ff < plen_ext);
   assign len_hi    = walking && (offset_ff == bound_ff + tlvpv_pkg::OFFSET_W'(2));
   assign len_lo    = walking && (offset_ff == bound_ff + tlvpv_pkg::OFFSET_W'(3));
   assign attr_len  = {cap_ff, item.byte_value};
   assign bound_sum = bound_ff + {1'b0, attr_len};

   // next state of the walk
   always_comb begin
      shift_in = shift_ff;
      cap_in   = cap_ff;
      bound_in = bound_ff;
      err_in   = err_ff;
      count_in = count_ff;
      if (in_header) begin
         shift_in = {shift_ff[55:0], item.byte_value};
      end else if (len_hi) begin
         cap_in = item.byte_value;
      end else if (len_lo) begin
         count_in = count_ff + tlvpv_pkg::COUNT_W'(1);
         if (attr_len < 16'(tlvpv_pkg::ATTR_HEADER_BYTES)) begin
            err_in = 1'b1;
         end else begin
            bound_in = bound_sum;
            if (bound_sum > plen_ext) begin
               err_in = 1'b1;
            end
         end
      end
      offset_in = (offset_ff == tlvpv_pkg::OFFSET_MAX) ? offset_ff
                : offset_ff + tlvpv_pkg::OFFSET_W'(1);
   end

   // result as seen after this byte
   assign new_plen  = {1'b0, shift_in[15:0]};
   assign short_buf = offset_in < tlvpv_pkg::HDR_LEN;

   always_comb begin
      if (short_buf) begin
         result = '0;
      end else begin
         result.packet_valid    = !err_in && (bound_in == new_plen) && (new_plen <= offset_in);
         result.request_number  = shift_in[63:32];
         result.request_type    = shift_in[31:16];
         result.packet_length   = shift_in[15:0];
         result.attribute_count = count_in;
      end
   end

   // control state, cleared after the last byte of each buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         bound_ff  <= tlvpv_pkg::HDR_LEN;
         err_ff    <= 1'b0;
         count_ff  <= '0;
      end else if (step) begin
         if (item.last_byte) begin
            offset_ff <= '0;
            bound_ff  <= tlvpv_pkg::HDR_LEN;
            err_ff    <= 1'b0;
            count_ff  <= '0;
         end else begin
            offset_ff <= offset_in;
            bound_ff  <= bound_in;
            err_ff    <= err_in;
            count_ff  <= count_in;
         end
      end
   end

   // header bytes and length high byte, refilled before every use
   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff <= shift_in;
         cap_ff   <= cap_in;
      end
   end

endmodule

### rtl/tlvpv_out_reg.sv
// result output register driving the response channel
module tlvpv_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tlvpv_pkg::result_type result,
   output logic                  free,
   tlvpv_rsp_if.source           rsp_if
);

   logic                  full_ff;
   tlvpv_pkg::result_type data_ff;

   // room for a new result when empty or when the held one transfers now
   assign free = !full_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (load) begin
         full_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   // drive the channel
   assign rsp_if.valid           = full_ff;
   assign rsp_if.packet_valid    = data_ff.packet_valid;
   assign rsp_if.request_number  = data_ff.request_number;
   assign rsp_if.request_type    = data_ff.request_type;
   assign rsp_if.packet_length   = data_ff.packet_length;
   assign rsp_if.attribute_count = data_ff.attribute_count;

endmodule

### rtl/tlv_packet_validator_top.sv
// top level of the tlv packet validator
//
// Checks a type-length-value request buffer streamed in one byte per transfer
// on req_if; last_byte marks the final byte of the buffer. The 8-byte header
// holds a request number, type and packet length, all big-endian, followed by
// a chain of attributes whose 16-bit lengths include their 4-byte header.
// For every buffer one result transfers on rsp_if: a valid flag, the header
// fields and the number of attribute headers read.
// Throughput is one byte per cycle unless a last byte finds the result register
// holding a result that is not taken; no gap is needed between buffers. A byte is
// taken into the input register; the walk state and the result register update
// as it leaves that register, so rsp_if.valid rises once the last byte has left it.
// Reset is synchronous: it empties both registers and restarts the walk at
// the start of a buffer. If the receiver holds rsp_if.ready low, bytes keep
// flowing until a last byte reaches the input register; that byte then waits
// there, and req_if.ready drops, until the held result transfers.
module tlv_packet_validator_top (
   input  logic        clock,
   input  logic        reset,
   tlvpv_req_if.sink   req_if,
   tlvpv_rsp_if.source rsp_if
);

   logic                  s1_valid_ff;
   tlvpv_pkg::item_type   s1_item_ff;
   logic                  s1_adv;
   logic                  out_free;
   tlvpv_pkg::result_type result;

   // input register advances unless a last byte finds the output busy
   assign s1_adv       = s1_valid_ff && (!s1_item_ff.last_byte || out_free);
   assign req_if.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_item_ff.byte_value <= req_if.byte_value;
         s1_item_ff.last_byte  <= req_if.last_byte;
      end
   end

   // chain walk
   tlvpv_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_adv),
      .item   (s1_item_ff),
      .result (result)
   );

   // result register
   tlvpv_out_reg u_out_reg (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_adv && s1_item_ff.last_byte),
      .result (result),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

`ifndef SYNTHESIS
   // a stalled byte stays in the input register unchanged
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("input register lost or changed a stalled byte");

   // an accepted byte lands in the input register
   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> s1_valid_ff)
      else $error("accepted byte not held in input register");

   // no result is presented right after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   // a valid packet always declares at least a full header
   a_valid_len: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.packet_valid
         |-> rsp_if.packet_length >= 16'(tlvpv_pkg::HEADER_BYTES))
      else $error("valid packet with length below header size");
`endif

endmodule

### dv/testbench.sv
// testbench for the tlv packet validator: random and directed buffers, predicted results
module testbench;
   import tlvpv_pkg::*;

   localparam int ITEM_TARGET     = 1850;
   localparam int IDLE_PERCENT    = 24;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RESULT_LATENCY  = 2;
   localparam int STALL_LIMIT     = 3000;

   // predicts the result of each buffer and checks the results in order
   class tlv_chain_scoreboard;
      logic [OFFSET_W-1:0] offset;
      logic [63:0]         header_bits;
      logic [OFFSET_W-1:0] boundary;
      logic [7:0]          length_high;
      logic                chain_broken;
      logic [COUNT_W-1:0]  attr_count;
      result_type          expected_results[$];
      int unsigned         mismatches;
      int unsigned         checked;
      int unsigned         valid_packets;

      function new();
         mismatches    = 0;
         checked       = 0;
         valid_packets = 0;
         restart();
      endfunction

      // walk state at the start of a buffer
      function void restart();
         offset       = '0;
         header_bits  = '0;
         boundary     = HDR_LEN;
         length_high  = '0;
         chain_broken = 1'b0;
         attr_count   = '0;
      endfunction

      // one accepted request byte, queues a result on the last byte
      function void note_byte(logic [7:0] value, logic last);
         logic [OFFSET_W-1:0] pos;
         logic [15:0]         plen;
         logic [15:0]         attr_len;
         result_type          predicted;
         pos  = offset;
         plen = header_bits[15:0];

         // header bytes shift in, then attribute lengths are picked off the chain
         if (pos < HDR_LEN) begin
            header_bits = {header_bits[55:0], value};
         end else if (!chain_broken && boundary < plen) begin
            if (pos == boundary + 2) begin
               length_high = value;
            end else if (pos == boundary + 3) begin
               attr_len   = {length_high, value};
               attr_count = attr_count + 1'b1;
               if (attr_len < ATTR_HEADER_BYTES) begin
                  chain_broken = 1'b1;
               end else begin
                  boundary = boundary + attr_len;
                  if (boundary > plen) begin
                     chain_broken = 1'b1;
                  end
               end
            end
         end

         if (pos != OFFSET_MAX) begin
            offset = pos + 1'b1;
         end
         if (!last) begin
            return;
         end

         // short buffers report all zeros
         predicted = '0;
         if (offset >= HDR_LEN) begin
            predicted.packet_valid    = !chain_broken && boundary == header_bits[15:0]
                                        && header_bits[15:0] <= offset;
            predicted.request_number  = header_bits[63:32];
            predicted.request_type    = header_bits[31:16];
            predicted.packet_length   = header_bits[15:0];
            predicted.attribute_count = attr_count;
         end
         expected_results.push_back(predicted);
         restart();
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch on result %0d, %s: got %0h, expected %0h", checked, what, got, want);
         mismatches++;
      endtask

      // compare one accepted result with the oldest prediction
      task check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", got.request_number, 0);
            return;
         end
         want = expected_results.pop_front();
         checked++;
         if (want.packet_valid) begin
            valid_packets++;
         end
         if (got.packet_valid !== want.packet_valid) begin
            report_mismatch("packet_valid", got.packet_valid, want.packet_valid);
         end
         if (got.request_number !== want.request_number) begin
            report_mismatch("request_number", got.request_number, want.request_number);
         end
         if (got.request_type !== want.request_type) begin
            report_mismatch("request_type", got.request_type, want.request_type);
         end
         if (got.packet_length !== want.packet_length) begin
            report_mismatch("packet_length", got.packet_length, want.packet_length);
         end
         if (got.attribute_count !== want.attribute_count) begin
            report_mismatch("attribute_count", got.attribute_count, want.attribute_count);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlvpv_req_if req_bus();
   tlvpv_rsp_if rsp_bus();

   tlv_packet_validator_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   tlv_chain_scoreboard scoreboard = new();

   logic [7:0]  frame[$];
   bit          steady          = 1'b0;
   bit          hold_off_request = 1'b0;
   int unsigned bytes_sent      = 0;
   int unsigned frames_sent     = 0;

   always #2 clock = ~clock;

   // known values on every input from the start
   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.byte_value <= '0;
      req_bus.last_byte  <= 1'b0;
      rsp_bus.ready      <= 1'b0;
   end

   // one byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value, input logic last);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.byte_value <= value;
      req_bus.last_byte  <= last;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      scoreboard.note_byte(value, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      for (int k = 0; k < frame.size(); k++) begin
         send_byte(frame[k], k == frame.size() - 1);
      end
      frames_sent++;
   endtask

   // well-formed buffer: header plus a consistent attribute chain
   task automatic build_chain_frame(input int attrs, input int shortest, input int longest);
      int          value_len;
      logic [15:0] attr_len;
      logic [15:0] plen;
      frame.delete();
      repeat (HEADER_BYTES) frame.push_back(8'($urandom));
      for (int k = 0; k < attrs; k++) begin
         value_len = $urandom_range(shortest, longest);
         attr_len  = 16'(ATTR_HEADER_BYTES + value_len);
         frame.push_back(8'($urandom));
         frame.push_back(8'($urandom));
         frame.push_back(attr_len[15:8]);
         frame.push_back(attr_len[7:0]);
         repeat (value_len) frame.push_back(8'($urandom));
      end
      plen     = 16'(frame.size());
      frame[6] = plen[15:8];
      frame[7] = plen[7:0];
   endtask

   // sender pause until every predicted result has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (scoreboard.expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // result side: checks each transfer, random stalls and one long hold-off
   initial begin : result_sink
      int holdoff_left;
      holdoff_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            scoreboard.check_result(result_type'({rsp_bus.packet_valid,
                                                  rsp_bus.request_number,
                                                  rsp_bus.request_type,
                                                  rsp_bus.packet_length,
                                                  rsp_bus.attribute_count}));
         end
         if (hold_off_request) begin
            holdoff_left     = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // ends the run when no transfer happens for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
             || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : stimulus
      int pick;
      int cut;
      int idx;
      int longest;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // short buffers: a lone byte, then one byte short of a header
      frame = '{8'hff};
      send_frame();
      frame.delete();
      repeat (7) frame.push_back(8'hff);
      send_frame();

      // header only, all-ones number and type
      build_chain_frame(0, 0, 0);
      for (int k = 0; k < 6; k++) frame[k] = 8'hff;
      send_frame();

      // all-zero header: packet length below the header size
      frame.delete();
      repeat (8) frame.push_back(8'h00);
      send_frame();

      // one minimal attribute
      build_chain_frame(1, 0, 0);
      send_frame();

      // attribute length of zero
      build_chain_frame(1, 0, 0);
      frame[10] = 8'h00;
      frame[11] = 8'h00;
      send_frame();

      // attribute length just under the attribute header
      build_chain_frame(1, 0, 0);
      frame[11] = 8'h03;
      send_frame();

      // attribute of maximum length runs past the packet end
      build_chain_frame(1, 0, 0);
      frame[10] = 8'hff;
      frame[11] = 8'hff;
      send_frame();

      // second attribute header cut off by the end of the buffer
      build_chain_frame(2, 0, 0);
      void'(frame.pop_back());
      void'(frame.pop_back());
      send_frame();

      // chain consistent but the buffer is shorter than the packet
      build_chain_frame(1, 4, 4);
      void'(frame.pop_back());
      void'(frame.pop_back());
      send_frame();

      // trailing bytes past the packet length are ignored
      build_chain_frame(2, 0, 3);
      repeat (3) frame.push_back(8'($urandom));
      send_frame();

      // error in the second attribute, which still counts
      build_chain_frame(3, 0, 0);
      frame[15] = 8'h01;
      send_frame();

      drain_results();

      // random buffers, mostly well-formed chains
      while (bytes_sent < ITEM_TARGET) begin
         if (frames_sent == 30) begin
            hold_off_request = 1'b1;
         end
         steady = (frames_sent >= 45 && frames_sent < 60);
         if (frames_sent == 70) begin
            drain_results();
         end

         longest = ($urandom_range(0, 49) == 0) ? 300 : 8;
         pick    = $urandom_range(0, 99);
         if (pick < 92) begin
            build_chain_frame($urandom_range(0, 4), 0, longest);
         end
         if (pick >= 65 && pick < 75) begin
            // truncated buffer
            cut = $urandom_range(1, frame.size() - 1);
            repeat (cut) void'(frame.pop_back());
         end else if (pick >= 75 && pick < 85) begin
            // one flipped bit past the request number and type fields
            idx        = $urandom_range(6, frame.size() - 1);
            frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
         end else if (pick >= 85 && pick < 92) begin
            // trailing bytes
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
         end else if (pick >= 92) begin
            // noise of random length
            frame.delete();
            repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
         end
         send_frame();
      end
      steady = 1'b0;

      drain_results();
      repeat (RESULT_LATENCY + 6) @(posedge clock);

      $display("summary: %0d buffers, %0d bytes, %0d results checked, %0d of them valid",
               frames_sent, bytes_sent, scoreboard.checked, scoreboard.valid_packets);
      $display("summary: included a long result hold-off, a full drain and an idle-free stretch");
      if (scoreboard.mismatches == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
